FILE: src/qfo_pkg.sv
`default_nettype none
package qfo_pkg;

    localparam int KEY_W   = 64;
    localparam int DIG_W   = 7;
    localparam int MS_W    = 10;
    localparam int FMT_W   = 2;
    localparam int VOL_W   = 40;
    localparam int PRICE_W = 48;
    localparam int STORE_W = PRICE_W + 1;
    localparam int TIME_W  = 29;
    localparam int SOD_W   = 19;
    localparam int STAT_W  = 2;

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;

    localparam logic [FMT_W-1:0] FMT_SHORT = 2'd0;
    localparam logic [FMT_W-1:0] FMT_LONG  = 2'd1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_STALE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // request travelling down the cell row
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  time_ms;
        logic [VOL_W-1:0]   volume;
        logic [PRICE_W-1:0] price;
        logic               present;
        logic               done;
        logic [STAT_W-1:0]  status;
        logic [STORE_W-1:0] open_p;
        logic [STORE_W-1:0] high_p;
        logic [STORE_W-1:0] low_p;
    } req_t;

endpackage
`default_nettype wire

FILE: src/quote_filter_ohlc_table_unit.sv
`default_nettype none
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | key 64, hour 7, minute 7, second 7, milli 10,        | format 2, price_present 1
//         |     | volume 40, price 48, pad 1                           |
// m_      | out | time_ms 29, open 48, high 48, low 48, pad 3          | status 2, open/high/low present
// One request at a time: from accept it passes the input registers, the seconds-of-day
// register, the head register, the row of cells (one cell a cycle) and the output register.
// The next request is taken the cycle after the result is taken.
// Reset empties the table at once (used bit per cell).
// m_tready low holds the result; s_tready stays low until it is taken.
module quote_filter_ohlc_table_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [183:0] s_tdata,  // key, hour, minute, second, milli, volume, price
    input  wire logic [2:0]   s_tuser,  // time_format, price_present
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata,  // time_ms, open, high, low
    output logic [4:0]        m_tuser   // status, open_present, high_present, low_present
);
    import qfo_pkg::*;

    logic               busy_reg;
    logic               st1_reg, st2_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DIG_W-1:0]   hh_reg, mm_reg, ss_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [FMT_W-1:0]   fmt_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               pres_reg;
    logic [SOD_W-1:0]   sod_reg;
    logic [TIME_W-1:0]  tms_next;
    logic               head_valid_reg;
    req_t               head_req_reg, head_req_next;
    logic               out_valid_reg;
    logic [175:0]       out_data_reg, out_data_next;
    logic [4:0]         out_user_reg, out_user_next;

    logic               chain_valid [TABLE_ENTRIES+1];
    req_t               chain_req   [TABLE_ENTRIES+1];

    logic in_fire, out_fire;
    assign s_tready = !busy_reg;
    assign in_fire  = s_tvalid && !busy_reg;
    assign out_fire = out_valid_reg && m_tready;

    always_comb begin
        case (fmt_reg)
            FMT_SHORT: tms_next = TIME_W'(sod_reg) * TIME_W'(MS_PER_SEC);
            FMT_LONG:  tms_next = TIME_W'(sod_reg) * TIME_W'(MS_PER_SEC) + TIME_W'(ms_reg);
            default:   tms_next = '0;
        endcase
        head_req_next         = '0;
        head_req_next.key     = key_reg;
        head_req_next.time_ms = tms_next;
        head_req_next.volume  = vol_reg;
        head_req_next.price   = price_reg;
        head_req_next.present = pres_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            st1_reg        <= 1'b0;
            st2_reg        <= 1'b0;
            head_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (out_fire) begin
                busy_reg <= 1'b0;
            end
            st1_reg        <= in_fire;
            st2_reg        <= st1_reg;
            head_valid_reg <= st2_reg;
            if (chain_valid[TABLE_ENTRIES]) begin
                out_valid_reg <= 1'b1;
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (in_fire) begin
            key_reg   <= s_tdata[63:0];
            hh_reg    <= s_tdata[70:64];
            mm_reg    <= s_tdata[77:71];
            ss_reg    <= s_tdata[84:78];
            ms_reg    <= s_tdata[94:85];
            vol_reg   <= s_tdata[134:95];
            price_reg <= s_tdata[182:135];
            fmt_reg   <= s_tuser[1:0];
            pres_reg  <= s_tuser[2];
        end
        if (st1_reg) begin
            sod_reg <= SOD_W'(hh_reg) * SOD_W'(SECS_PER_HOUR)
                     + SOD_W'(mm_reg) * SOD_W'(SECS_PER_MIN)
                     + SOD_W'(ss_reg);
        end
        if (st2_reg) begin
            head_req_reg <= head_req_next;
        end
        if (chain_valid[TABLE_ENTRIES]) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_req[0]   = head_req_reg;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        qfo_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_req    (chain_req[g]),
            .out_valid (chain_valid[g+1]),
            .out_req   (chain_req[g+1])
        );
    end

    // no cell took the key: table full, prices cleared
    always_comb begin
        req_t r;
        r = chain_req[TABLE_ENTRIES];
        if (!r.done) begin
            out_data_next = {3'd0, {PRICE_W{1'b0}}, {PRICE_W{1'b0}}, {PRICE_W{1'b0}},
                             r.time_ms};
            out_user_next = {3'b000, STATUS_FULL};
        end else begin
            out_data_next = {3'd0, r.low_p[PRICE_W-1:0], r.high_p[PRICE_W-1:0],
                             r.open_p[PRICE_W-1:0], r.time_ms};
            out_user_next = {r.low_p[PRICE_W], r.high_p[PRICE_W], r.open_p[PRICE_W],
                             r.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

FILE: src/qfo_cell.sv
`default_nettype none
module qfo_cell (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire qfo_pkg::req_t in_req,
    output logic              out_valid,
    output qfo_pkg::req_t     out_req
);
    import qfo_pkg::*;

    logic               used_reg, used_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [VOL_W-1:0]   vol_reg, vol_next;
    logic [STORE_W-1:0] open_reg, open_next;
    logic [STORE_W-1:0] high_reg, high_next;
    logic [STORE_W-1:0] low_reg, low_next;
    logic               valid_reg;
    req_t               req_reg, req_next;
    logic               price_pos;
    logic [STORE_W-1:0] new_p;

    assign price_pos = !in_req.price[PRICE_W-1] && (in_req.price != '0);
    assign new_p     = {in_req.present, in_req.price};

    always_comb begin
        used_next = used_reg;
        key_next  = key_reg;
        time_next = time_reg;
        vol_next  = vol_reg;
        open_next = open_reg;
        high_next = high_reg;
        low_next  = low_reg;
        req_next  = in_req;
        if (in_valid && !in_req.done) begin
            if (used_reg && (key_reg == in_req.key)) begin
                req_next.done = 1'b1;
                if ((in_req.time_ms < time_reg) || (in_req.volume < vol_reg)) begin
                    time_next = in_req.time_ms;
                    vol_next  = in_req.volume;
                    req_next.status = STATUS_STALE;
                end else begin
                    req_next.status = STATUS_OK;
                    if (in_req.present) begin
                        if (!open_reg[PRICE_W] && price_pos) begin
                            open_next = new_p;
                        end
                        if (high_reg[PRICE_W] &&
                            ($signed(in_req.price) > $signed(high_reg[PRICE_W-1:0]))) begin
                            high_next = new_p;
                        end
                        if (low_reg[PRICE_W] &&
                            ($signed(in_req.price) < $signed(low_reg[PRICE_W-1:0]))) begin
                            low_next = new_p;
                        end
                    end
                end
                req_next.open_p = open_next;
                req_next.high_p = high_next;
                req_next.low_p  = low_next;
            end else if (!used_reg) begin
                used_next = 1'b1;
                key_next  = in_req.key;
                time_next = in_req.time_ms;
                vol_next  = in_req.volume;
                open_next = new_p;
                high_next = new_p;
                low_next  = new_p;
                req_next.done   = 1'b1;
                req_next.status = STATUS_OK;
                req_next.open_p = new_p;
                req_next.high_p = new_p;
                req_next.low_p  = new_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            used_reg  <= used_next;
            valid_reg <= in_valid;
        end
        key_reg  <= key_next;
        time_reg <= time_next;
        vol_reg  <= vol_next;
        open_reg <= open_next;
        high_reg <= high_next;
        low_reg  <= low_next;
        req_reg  <= req_next;
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;

endmodule
`default_nettype wire
